// ----- sv/cac_pkg.sv -----
// ============================================================================
// cac_pkg
// Shared types and constants of the checked address/constant ALU.
// ============================================================================
package cac_pkg;

    // Operation codes of an input transaction.
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MOD = 3'd4;

    // Operand kind codes.
    localparam logic [2:0] KIND_CONST = 3'd0;
    localparam logic [2:0] KIND_INT   = 3'd1;
    localparam logic [2:0] KIND_ADDR  = 3'd2;
    localparam logic [2:0] KIND_RANGE = 3'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Result kind codes.
    localparam logic RK_CONST = 1'b0;
    localparam logic RK_ADDR  = 1'b1;

    // Multiplier digit width and padded operand width.
    localparam int DIG_W = 32;
    localparam int MUL_W = 64;

    // Operation class decided by the front end.
    typedef enum logic [3:0] {
        CLS_INV   = 4'd0,
        CLS_ADD   = 4'd1,
        CLS_SUB   = 4'd2,
        CLS_PADD  = 4'd3,
        CLS_PSUB  = 4'd4,
        CLS_PDIFF = 4'd5,
        CLS_MUL   = 4'd6,
        CLS_DIV   = 4'd7,
        CLS_MOD   = 4'd8
    } cls_t;

    // Back end sequencer states.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } bstate_t;

    function automatic logic is_const_kind(input logic [2:0] k);
        is_const_kind = (k == KIND_CONST) || (k == KIND_INT);
    endfunction

    function automatic logic is_addr_kind(input logic [2:0] k);
        is_addr_kind = (k == KIND_ADDR) || (k == KIND_RANGE);
    endfunction

endpackage

// ----- sv/cac_in_if.sv -----
// ============================================================================
// cac_in_if
// Input channel: operation and two tagged operands.
// ============================================================================
interface cac_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [2:0]  lhs_kind;
    logic [63:0] lhs_value;
    logic [2:0]  rhs_kind;
    logic [63:0] rhs_value;

    modport source (output valid, op, lhs_kind, lhs_value, rhs_kind, rhs_value,
                    input ready);
    modport sink (input valid, op, lhs_kind, lhs_value, rhs_kind, rhs_value,
                  output ready);
endinterface

// ----- sv/cac_out_if.sv -----
// ============================================================================
// cac_out_if
// Output channel: status, result kind and result value.
// ============================================================================
interface cac_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        result_kind;
    logic [63:0] result_value;

    modport source (output valid, status, result_kind, result_value, input ready);
    modport sink (input valid, status, result_kind, result_value, output ready);
endinterface

// ----- sv/cac_front.sv -----
// ============================================================================
// cac_front
// Classifies a transaction by operation and operand kinds and orders operands.
// ============================================================================
module cac_front #(
    parameter int W = 64
) (
    input  logic [2:0]    op,
    input  logic [2:0]    lhs_kind,
    input  logic [63:0]   lhs_value,
    input  logic [2:0]    rhs_kind,
    input  logic [63:0]   rhs_value,
    output cac_pkg::cls_t cls,
    output logic [W-1:0]  a,
    output logic [W-1:0]  b
);
    import cac_pkg::*;

    logic [W-1:0] lv;
    logic [W-1:0] rv;
    logic         lc;
    logic         rc;
    logic         la;
    logic         ra;
    logic         addsub;

    assign lv     = lhs_value[W-1:0];
    assign rv     = rhs_value[W-1:0];
    assign lc     = is_const_kind(lhs_kind);
    assign rc     = is_const_kind(rhs_kind);
    assign la     = is_addr_kind(lhs_kind);
    assign ra     = is_addr_kind(rhs_kind);
    assign addsub = (op == OP_ADD) || (op == OP_SUB);

    // Pointer rules first, then plain signed arithmetic on constants.
    always_comb
    begin
        cls = CLS_INV;
        a   = lv;
        b   = rv;
        priority if (addsub && (la || ra))
        begin
            if (la && ra)
            begin
                if (op == OP_SUB)
                begin
                    cls = CLS_PDIFF;
                end
            end
            else if (la)
            begin
                if (rc)
                begin
                    cls = (op == OP_ADD) ? CLS_PADD : CLS_PSUB;
                end
            end
            else if ((op == OP_ADD) && lc)
            begin
                // Constant plus address: put the address on the left.
                cls = CLS_PADD;
                a   = rv;
                b   = lv;
            end
        end
        else if (lc && rc)
        begin
            unique case (op)
                OP_ADD:  cls = CLS_ADD;
                OP_SUB:  cls = CLS_SUB;
                OP_MUL:  cls = CLS_MUL;
                OP_DIV:  cls = (rv == '0) ? CLS_INV : CLS_DIV;
                OP_MOD:  cls = (rv == '0) ? CLS_INV : CLS_MOD;
                default: cls = CLS_INV;
            endcase
        end
        else
        begin
            // Any other operand kind is rejected.
            cls = CLS_INV;
        end
    end

endmodule

// ----- sv/cac_queue.sv -----
// ============================================================================
// cac_queue
// Two-entry queue between the front end and the back end.
// ============================================================================
module cac_queue #(
    parameter int DW = 132
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output logic [DW-1:0] head
);
    logic [DW-1:0] mem_reg [2];
    logic          wp_reg;
    logic          wp_next;
    logic          rp_reg;
    logic          rp_next;
    logic [1:0]    cnt_reg;
    logic [1:0]    cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = mem_reg[rp_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

endmodule

// ----- sv/cac_back.sv -----
// ============================================================================
// cac_back
// Executes classified transactions and holds the result in an output register.
// ============================================================================
module cac_back #(
    parameter int W = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  cac_pkg::cls_t q_cls,
    input  logic [W-1:0]  q_a,
    input  logic [W-1:0]  q_b,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    out_status,
    output logic          out_rkind,
    output logic [63:0]   out_value
);
    import cac_pkg::*;

    localparam int DCW = $clog2(W);

    bstate_t                  st_reg;
    bstate_t                  st_next;
    cls_t                     cls_reg;
    logic                     neg_reg;
    logic                     sa_reg;
    logic                     spec_reg;
    logic [MUL_W-1:0]         ma_reg;
    logic [MUL_W-1:0]         mb_reg;
    logic [2*MUL_W-1:0]       acc_reg;
    logic [1:0]               step_reg;
    logic [W-1:0]             quo_reg;
    logic [W:0]               rem_reg;
    logic [DCW-1:0]           cnt_reg;
    logic                     ov_reg;
    logic [1:0]               ost_reg;
    logic                     okind_reg;
    logic [63:0]              oval_reg;

    logic                     out_free;
    logic                     sa;
    logic                     sb;
    logic [W-1:0]             ma;
    logic [W-1:0]             mb;
    logic [W:0]               sum;
    logic [W:0]               dif;
    logic [W+1:0]             pt;
    logic [W:0]               pd;
    logic                     simple;
    logic [1:0]               s_st;
    logic                     s_kind;
    logic [W-1:0]             s_val;
    logic [DIG_W-1:0]         dig_a;
    logic [DIG_W-1:0]         dig_b;
    logic [2*DIG_W-1:0]       pp;
    logic [6:0]               pp_sh;
    logic [W:0]               rem_sh;
    logic [W:0]               rem_sub;
    logic                     qbit;
    logic [2*MUL_W-1:0]       lim;
    logic [1:0]               f_st;
    logic [W-1:0]             f_val;
    logic                     take;
    logic                     wr_simple;
    logic                     wr_fin;

    assign out_free   = !ov_reg || out_ready;
    assign out_valid  = ov_reg;
    assign out_status = ost_reg;
    assign out_rkind  = okind_reg;
    assign out_value  = oval_reg;

    // Signs and magnitudes of the head operands.
    assign sa = q_a[W-1];
    assign sb = q_b[W-1];
    assign ma = sa ? (~q_a + 1'b1) : q_a;
    assign mb = sb ? (~q_b + 1'b1) : q_b;

    // Classes done without the sequencer: signed add/sub, pointer arithmetic and invalid.
    always_comb
    begin
        sum    = {q_a[W-1], q_a} + {q_b[W-1], q_b};
        dif    = {q_a[W-1], q_a} - {q_b[W-1], q_b};
        pt     = (q_cls == CLS_PSUB) ? ({2'b00, q_a} - {{2{q_b[W-1]}}, q_b})
                                     : ({2'b00, q_a} + {{2{q_b[W-1]}}, q_b});
        pd     = {1'b0, q_a} - {1'b0, q_b};
        simple = 1'b1;
        s_kind = RK_CONST;
        s_val  = '0;
        s_st   = ST_INVALID;
        unique case (q_cls)
            CLS_ADD:
            begin
                s_st  = (sum[W] != sum[W-1]) ? ST_OVERFLOW : ST_OK;
                s_val = sum[W-1:0];
            end
            CLS_SUB:
            begin
                s_st  = (dif[W] != dif[W-1]) ? ST_OVERFLOW : ST_OK;
                s_val = dif[W-1:0];
            end
            CLS_PADD, CLS_PSUB:
            begin
                s_st   = (pt[W+1:W] != 2'b00) ? ST_OVERFLOW : ST_OK;
                s_val  = pt[W-1:0];
                s_kind = RK_ADDR;
            end
            CLS_PDIFF:
            begin
                s_st  = (pd[W] != pd[W-1]) ? ST_OVERFLOW : ST_OK;
                s_val = pd[W-1:0];
            end
            CLS_MUL, CLS_DIV, CLS_MOD:
            begin
                simple = 1'b0;
            end
            default:
            begin
                s_st = ST_INVALID;
            end
        endcase
        if (s_st != ST_OK)
        begin
            s_kind = RK_CONST;
            s_val  = '0;
        end
    end

    // One 32x32 partial product per multiply step.
    always_comb
    begin
        dig_a = step_reg[1] ? ma_reg[2*DIG_W-1:DIG_W] : ma_reg[DIG_W-1:0];
        dig_b = step_reg[0] ? mb_reg[2*DIG_W-1:DIG_W] : mb_reg[DIG_W-1:0];
        pp    = dig_a * dig_b;
        pp_sh = {2'({1'b0, step_reg[1]} + {1'b0, step_reg[0]}), 5'b00000};
    end

    // One restoring division step.
    always_comb
    begin
        rem_sh  = {rem_reg[W-1:0], quo_reg[W-1]};
        rem_sub = rem_sh - {1'b0, mb_reg[W-1:0]};
        qbit    = (rem_sh >= {1'b0, mb_reg[W-1:0]});
    end

    // Range check and sign of a multi-cycle result.
    always_comb
    begin
        lim   = (2*MUL_W)'(1) << (W - 1);
        f_st  = ST_OK;
        f_val = '0;
        unique case (cls_reg)
            CLS_MUL:
            begin
                if (acc_reg > (neg_reg ? lim : (lim - 1'b1)))
                begin
                    f_st = ST_OVERFLOW;
                end
                f_val = neg_reg ? (~acc_reg[W-1:0] + 1'b1) : acc_reg[W-1:0];
            end
            CLS_DIV:
            begin
                if (!neg_reg && quo_reg[W-1])
                begin
                    f_st = ST_OVERFLOW;
                end
                f_val = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
            end
            default:
            begin
                if (spec_reg)
                begin
                    f_st = ST_OVERFLOW;
                end
                f_val = sa_reg ? (~rem_reg[W-1:0] + 1'b1) : rem_reg[W-1:0];
            end
        endcase
        if (f_st != ST_OK)
        begin
            f_val = '0;
        end
    end

    // Sequencer control.
    always_comb
    begin
        st_next   = st_reg;
        take      = 1'b0;
        wr_simple = 1'b0;
        wr_fin    = 1'b0;
        unique case (st_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    if (simple)
                    begin
                        if (out_free)
                        begin
                            take      = 1'b1;
                            wr_simple = 1'b1;
                        end
                    end
                    else
                    begin
                        take    = 1'b1;
                        st_next = (q_cls == CLS_MUL) ? S_MUL : S_DIV;
                    end
                end
            end
            S_MUL:
            begin
                if (step_reg == 2'd3)
                begin
                    st_next = S_FIN;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    st_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    wr_fin  = 1'b1;
                    st_next = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    assign q_pop = take;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (wr_simple || wr_fin)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (take && !simple)
        begin
            cls_reg  <= q_cls;
            neg_reg  <= sa ^ sb;
            sa_reg   <= sa;
            spec_reg <= sa && sb && (ma == (W'(1) << (W - 1))) && (mb == W'(1));
            ma_reg   <= MUL_W'(ma);
            mb_reg   <= MUL_W'(mb);
            acc_reg  <= '0;
            step_reg <= 2'd0;
            quo_reg  <= ma;
            rem_reg  <= '0;
            cnt_reg  <= DCW'(W - 1);
        end
        if (st_reg == S_MUL)
        begin
            acc_reg  <= acc_reg + ((2*MUL_W)'(pp) << pp_sh);
            step_reg <= step_reg + 2'd1;
        end
        if (st_reg == S_DIV)
        begin
            rem_reg <= qbit ? rem_sub : rem_sh;
            quo_reg <= {quo_reg[W-2:0], qbit};
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (wr_simple)
        begin
            ost_reg   <= s_st;
            okind_reg <= s_kind;
            oval_reg  <= 64'(s_val);
        end
        if (wr_fin)
        begin
            ost_reg   <= f_st;
            okind_reg <= RK_CONST;
            oval_reg  <= 64'(f_val);
        end
    end

endmodule

// ----- sv/checked_address_const_alu.sv -----
// ============================================================================
// checked_address_const_alu
// Overflow-checked integer ALU with address (pointer) arithmetic rules.
// ============================================================================
// Usage:
//   in_ch carries one transaction per operation: op and two tagged operands.
//   out_ch returns exactly one transaction per input: status, result kind
//   and result value, in input order.
//   The front end classifies each transaction and writes it to a two-entry
//   queue; the back end executes it and holds the result in an output
//   register, so a new input is taken while a result waits on out_ch.
//   Add, subtract, pointer arithmetic and every invalid transaction are done
//   by the back end straight from the queue head, so they stream at one per
//   cycle while out_ch is not stalled and no multiply or divide is running.
//   Multiply is loaded, then runs four 32x32 multiplier steps and ends with
//   a range check before the result is written to the output register.
//   Divide and modulo use a radix-2 restoring divider, one quotient bit per
//   cycle, between a load step and a final step that sets sign and status.
//   A stalled out_ch holds its result; the queue then fills and in_ch.ready
//   drops. Reset clears the queue, the sequencer and the output valid.
// ============================================================================
module checked_address_const_alu #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    cac_in_if.sink    in_ch,
    cac_out_if.source out_ch
);
    import cac_pkg::*;

    localparam int QW = $bits(cls_t) + 2 * VALUE_WIDTH;

    cls_t                   f_cls;
    logic [VALUE_WIDTH-1:0] f_a;
    logic [VALUE_WIDTH-1:0] f_b;
    logic                   q_full;
    logic                   q_empty;
    logic                   q_pop;
    logic [QW-1:0]          q_head;
    cls_t                   h_cls;
    logic [VALUE_WIDTH-1:0] h_a;
    logic [VALUE_WIDTH-1:0] h_b;

    assign in_ch.ready = !q_full;

    // Classification of the incoming transaction.
    cac_front #(
        .W (VALUE_WIDTH)
    ) u_front (
        .op        (in_ch.op),
        .lhs_kind  (in_ch.lhs_kind),
        .lhs_value (in_ch.lhs_value),
        .rhs_kind  (in_ch.rhs_kind),
        .rhs_value (in_ch.rhs_value),
        .cls       (f_cls),
        .a         (f_a),
        .b         (f_b)
    );

    // Queue between front and back end.
    cac_queue #(
        .DW (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_ch.valid && !q_full),
        .push_data ({f_cls, f_a, f_b}),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    assign h_cls = cls_t'(q_head[QW-1 -: $bits(cls_t)]);
    assign h_a   = q_head[2*VALUE_WIDTH-1:VALUE_WIDTH];
    assign h_b   = q_head[VALUE_WIDTH-1:0];

    // Execution and output register.
    cac_back #(
        .W (VALUE_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_cls      (h_cls),
        .q_a        (h_a),
        .q_b        (h_b),
        .q_pop      (q_pop),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_status (out_ch.status),
        .out_rkind  (out_ch.result_kind),
        .out_value  (out_ch.result_value)
    );

endmodule
